// ===== rtl/core/wfbs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Window fill byte streamer package
// Shared queue entry type, panel command bytes, header phase codes and the
// window byte selector.
// ----------------------------------------------------------------------------
package wfbs_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam logic [7:0] CMD_COLUMN   = 8'h2A;
  localparam logic [7:0] CMD_ROW      = 8'h2B;
  localparam logic [7:0] CMD_MEMWRITE = 8'h2C;
  localparam logic [7:0] BYTE_MASK    = 8'hFF;

  localparam logic [3:0] PH_COL_CMD   = 4'd0;
  localparam logic [3:0] PH_COL_FIRST = 4'd1;
  localparam logic [3:0] PH_COL_LAST  = 4'd4;
  localparam logic [3:0] PH_ROW_CMD   = 4'd5;
  localparam logic [3:0] PH_ROW_FIRST = 4'd6;
  localparam logic [3:0] PH_ROW_LAST  = 4'd9;
  localparam logic [3:0] PH_MEM_CMD   = 4'd10;
  localparam logic [3:0] PH_PIXELS    = 4'd11;

  localparam logic [1:0] WB_START_HI = 2'd0;
  localparam logic [1:0] WB_START_LO = 2'd1;
  localparam logic [1:0] WB_END_HI   = 2'd2;
  localparam logic [1:0] WB_END_LO   = 2'd3;

  typedef struct packed {
    logic        is_tick;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] color;
  } entry_t;

  function automatic logic [7:0] win_byte(input logic [15:0] start_v,
                                          input logic [15:0] end_v,
                                          input logic [1:0]  idx);
    logic [7:0] b;
    begin
      case (idx)
        WB_START_HI: b = start_v[15:8] & BYTE_MASK;
        WB_START_LO: b = start_v[7:0] & BYTE_MASK;
        WB_END_HI:   b = end_v[15:8] & BYTE_MASK;
        default:     b = end_v[7:0] & BYTE_MASK;
      endcase
      return b;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/wfbs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Window fill byte streamer front end
// Accepts input beats, drops off-panel and empty requests, clips the size of
// remaining requests to the panel edge and pushes them and ticks to the queue.
// ----------------------------------------------------------------------------
module wfbs_front #(
  parameter int unsigned PANEL_WIDTH  = 240,
  parameter int unsigned PANEL_HEIGHT = 240
) (
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             op_i,
  input  wire logic [15:0]      rect_x_i,
  input  wire logic [15:0]      rect_y_i,
  input  wire logic [15:0]      rect_w_i,
  input  wire logic [15:0]      rect_h_i,
  input  wire logic [15:0]      fill_color_i,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output wfbs_pkg::entry_t      entry_o
);

  localparam logic [16:0] PanelW17 = 17'(PANEL_WIDTH);
  localparam logic [16:0] PanelH17 = 17'(PANEL_HEIGHT);
  localparam logic [15:0] PanelW16 = 16'(PANEL_WIDTH);
  localparam logic [15:0] PanelH16 = 16'(PANEL_HEIGHT);

  logic [16:0] x_sum;
  logic [16:0] y_sum;
  logic [15:0] w_clip;
  logic [15:0] h_clip;
  logic        on_panel;
  logic        req_ok;

  assign x_sum    = {1'b0, rect_x_i} + {1'b0, rect_w_i};
  assign y_sum    = {1'b0, rect_y_i} + {1'b0, rect_h_i};
  assign w_clip   = (x_sum > PanelW17) ? (PanelW16 - rect_x_i) : rect_w_i;
  assign h_clip   = (y_sum > PanelH17) ? (PanelH16 - rect_y_i) : rect_h_i;
  assign on_panel = (rect_x_i < PanelW16) && (rect_y_i < PanelH16);
  assign req_ok   = on_panel && (w_clip != '0) && (h_clip != '0);

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && (op_i || req_ok);

  always_comb begin
    entry_o.is_tick = op_i;
    entry_o.x       = rect_x_i;
    entry_o.y       = rect_y_i;
    entry_o.w       = w_clip;
    entry_o.h       = h_clip;
    entry_o.color   = fill_color_i;
  end

endmodule
`default_nettype wire

// ===== rtl/core/wfbs_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Window fill byte streamer queue
// Short first-in first-out buffer between the front end and the sequencer.
// ----------------------------------------------------------------------------
module wfbs_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wfbs_pkg::entry_t      push_entry_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  head_valid_o,
  output wfbs_pkg::entry_t      head_o
);

  localparam int unsigned CntW = wfbs_pkg::QPtrW + 1;

  wfbs_pkg::entry_t mem_q [wfbs_pkg::QDepth];

  logic [wfbs_pkg::QPtrW-1:0] wr_ptr_q;
  logic [wfbs_pkg::QPtrW-1:0] rd_ptr_q;
  logic [CntW-1:0]            count_q;
  logic                       do_push;
  logic                       do_pop;

  assign full_o       = (count_q == CntW'(wfbs_pkg::QDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/wfbs_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Window fill byte streamer sequencer
// Takes queued requests and ticks in order, holds the fill state and sends
// one tagged byte per tick during a fill through a registered output stage.
// ----------------------------------------------------------------------------
module wfbs_back #(
  parameter int unsigned PANEL_WIDTH  = 240,
  parameter int unsigned PANEL_HEIGHT = 240
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             head_valid_i,
  input  wfbs_pkg::entry_t      head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [7:0]            spi_byte_o,
  output logic                  is_data_o,
  output logic                  release_select_o,
  output logic                  fill_done_o
);

  localparam int unsigned CW  = $clog2(PANEL_WIDTH + 1);
  localparam int unsigned CH  = $clog2(PANEL_HEIGHT + 1);
  localparam int unsigned PLW = CW + CH;

  logic            busy_q,     busy_d;
  logic [3:0]      phase_q,    phase_d;
  logic [15:0]     xs_q,       xs_d;
  logic [15:0]     xe_q,       xe_d;
  logic [15:0]     ys_q,       ys_d;
  logic [15:0]     ye_q,       ye_d;
  logic [15:0]     color_q,    color_d;
  logic [PLW-1:0]  pix_q,      pix_d;
  logic            low_q,      low_d;
  logic            ovalid_q,   ovalid_d;
  logic [7:0]      obyte_q,    obyte_d;
  logic            odata_q,    odata_d;
  logic            orel_q,     orel_d;
  logic            odone_q,    odone_d;

  logic            out_free;
  logic            emit;
  logic [PLW-1:0]  pix_dec;

  assign out_free = !ovalid_q || !out_stall_i;
  assign emit     = head_valid_i && head_i.is_tick && busy_q && out_free;
  assign pop_o    = head_valid_i && (!(head_i.is_tick && busy_q) || out_free);
  assign pix_dec  = (pix_q != '0) ? (pix_q - PLW'(1)) : pix_q;

  always_comb begin
    busy_d   = busy_q;
    phase_d  = phase_q;
    xs_d     = xs_q;
    xe_d     = xe_q;
    ys_d     = ys_q;
    ye_d     = ye_q;
    color_d  = color_q;
    pix_d    = pix_q;
    low_d    = low_q;
    obyte_d  = obyte_q;
    odata_d  = odata_q;
    orel_d   = orel_q;
    odone_d  = odone_q;
    ovalid_d = out_stall_i ? ovalid_q : 1'b0;

    if (head_valid_i && !head_i.is_tick && !busy_q) begin
      xs_d    = head_i.x;
      xe_d    = 16'(head_i.x + head_i.w - 16'd1);
      ys_d    = head_i.y;
      ye_d    = 16'(head_i.y + head_i.h - 16'd1);
      color_d = head_i.color;
      pix_d   = PLW'(head_i.w[CW-1:0]) * PLW'(head_i.h[CH-1:0]);
      low_d   = 1'b0;
      phase_d = wfbs_pkg::PH_COL_CMD;
      busy_d  = 1'b1;
    end

    if (emit) begin
      ovalid_d = 1'b1;
      obyte_d  = '0;
      odata_d  = 1'b0;
      orel_d   = 1'b0;
      odone_d  = 1'b0;
      if (phase_q == wfbs_pkg::PH_COL_CMD) begin
        obyte_d = wfbs_pkg::CMD_COLUMN;
        orel_d  = 1'b1;
        phase_d = wfbs_pkg::PH_COL_FIRST;
      end else if (phase_q <= wfbs_pkg::PH_COL_LAST) begin
        obyte_d = wfbs_pkg::win_byte(xs_q, xe_q, 2'(phase_q - wfbs_pkg::PH_COL_FIRST));
        odata_d = 1'b1;
        orel_d  = (phase_q == wfbs_pkg::PH_COL_LAST);
        phase_d = phase_q + 4'd1;
      end else if (phase_q == wfbs_pkg::PH_ROW_CMD) begin
        obyte_d = wfbs_pkg::CMD_ROW;
        orel_d  = 1'b1;
        phase_d = wfbs_pkg::PH_ROW_FIRST;
      end else if (phase_q <= wfbs_pkg::PH_ROW_LAST) begin
        obyte_d = wfbs_pkg::win_byte(ys_q, ye_q, 2'(phase_q - wfbs_pkg::PH_ROW_FIRST));
        odata_d = 1'b1;
        orel_d  = (phase_q == wfbs_pkg::PH_ROW_LAST);
        phase_d = phase_q + 4'd1;
      end else if (phase_q == wfbs_pkg::PH_MEM_CMD) begin
        obyte_d = wfbs_pkg::CMD_MEMWRITE;
        orel_d  = 1'b1;
        phase_d = wfbs_pkg::PH_PIXELS;
      end else begin
        odata_d = 1'b1;
        if (!low_q) begin
          obyte_d = color_q[15:8];
          low_d   = 1'b1;
        end else begin
          obyte_d = color_q[7:0];
          low_d   = 1'b0;
          pix_d   = pix_dec;
          if (pix_dec == '0) begin
            orel_d  = 1'b1;
            odone_d = 1'b1;
            busy_d  = 1'b0;
            phase_d = wfbs_pkg::PH_COL_CMD;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      phase_q  <= wfbs_pkg::PH_COL_CMD;
      pix_q    <= '0;
      low_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      phase_q  <= phase_d;
      pix_q    <= pix_d;
      low_q    <= low_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xs_q    <= xs_d;
    xe_q    <= xe_d;
    ys_q    <= ys_d;
    ye_q    <= ye_d;
    color_q <= color_d;
    obyte_q <= obyte_d;
    odata_q <= odata_d;
    orel_q  <= orel_d;
    odone_q <= odone_d;
  end

  assign out_valid_o      = ovalid_q;
  assign spi_byte_o       = obyte_q;
  assign is_data_o        = odata_q;
  assign release_select_o = orel_q;
  assign fill_done_o      = odone_q;

endmodule
`default_nettype wire

// ===== rtl/core/window_fill_byte_streamer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Window fill byte streamer
// Streams the address window header and pixel bytes of a rectangle fill.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o. A beat with op_i low is a fill
// request (rect_x_i, rect_y_i, rect_w_i, rect_h_i, fill_color_i); a beat with
// op_i high is a tick that sends one byte in a fill. Requests that start off
// the panel, have zero size, or arrive while a fill runs give no output beat.
// Output channel: out_valid_o / out_stall_i, carrying spi_byte_o with its
// command/data, chip-select release and end-of-fill tags.
// A tick during a fill sends its byte through the output register once that
// register is free. One beat per cycle is sustained in both directions while
// the output is not stalled; the sequencer emits at most one byte per cycle.
// The front end and the sequencer are separated by a four-entry queue, so
// input beats keep being taken while the output is stalled until the queue
// fills; then in_stall_o rises. A stalled output beat holds its value.
// Reset clears the queue, the fill state and the output register.
// ----------------------------------------------------------------------------
module window_fill_byte_streamer_top #(
  parameter int unsigned PANEL_WIDTH  = 240,
  parameter int unsigned PANEL_HEIGHT = 240
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        op_i,
  input  wire logic [15:0] rect_x_i,
  input  wire logic [15:0] rect_y_i,
  input  wire logic [15:0] rect_w_i,
  input  wire logic [15:0] rect_h_i,
  input  wire logic [15:0] fill_color_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       spi_byte_o,
  output logic             is_data_o,
  output logic             release_select_o,
  output logic             fill_done_o
);

  logic             push;
  logic             q_full;
  logic             pop;
  logic             head_valid;
  wfbs_pkg::entry_t push_entry;
  wfbs_pkg::entry_t head;

  wfbs_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .rect_x_i     (rect_x_i),
    .rect_y_i     (rect_y_i),
    .rect_w_i     (rect_w_i),
    .rect_h_i     (rect_h_i),
    .fill_color_i (fill_color_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  wfbs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  wfbs_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .spi_byte_o       (spi_byte_o),
    .is_data_o        (is_data_o),
    .release_select_o (release_select_o),
    .fill_done_o      (fill_done_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/wfbs_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Window fill byte streamer checker
// Port-level properties of the output byte stream.
// ----------------------------------------------------------------------------
module wfbs_port_props (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_stall_i,
  input wire logic [7:0] spi_byte_i,
  input wire logic       is_data_i,
  input wire logic       release_select_i,
  input wire logic       fill_done_i
);

  a_done_tags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && fill_done_i) |-> (is_data_i && release_select_i))
    else $error("End-of-fill beat is not a data beat that releases select.");

  a_cmd_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !is_data_i) |->
      (release_select_i && !fill_done_i &&
       (spi_byte_i == wfbs_pkg::CMD_COLUMN || spi_byte_i == wfbs_pkg::CMD_ROW ||
        spi_byte_i == wfbs_pkg::CMD_MEMWRITE)))
    else $error("Command beat carries an unexpected byte or tags.");

  a_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_stall_i && !is_data_i && spi_byte_i == wfbs_pkg::CMD_MEMWRITE)
      ##1 out_valid_i |-> is_data_i)
    else $error("Beat after memory write command is not pixel data.");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |=>
      (out_valid_i && $stable(spi_byte_i) && $stable(fill_done_i)))
    else $error("Stalled output beat changed.");

endmodule

bind window_fill_byte_streamer_top wfbs_port_props u_wfbs_port_props (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .spi_byte_i       (spi_byte_o),
  .is_data_i        (is_data_o),
  .release_select_i (release_select_o),
  .fill_done_i      (fill_done_o)
);
`default_nettype wire
